>>> sv/hash_set_linear_probe_unit_macros.svh
// Assertion macros used by the hash set RTL.
`ifndef HASH_SET_LINEAR_PROBE_UNIT_MACROS_SVH
`define HASH_SET_LINEAR_PROBE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define HSLP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("hslp assertion failed");
`define HSLP_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("hslp assertion failed");
`else
`define HSLP_ASSERT(lbl, clk, rst, prop)
`define HSLP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> sv/hslp_pkg.sv
package hslp_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;

   localparam int KEY_HEAD_W = 64;
   localparam int KEY_TAIL_W = 24;
   localparam int KEY_W      = KEY_HEAD_W + KEY_TAIL_W;
   localparam int HASH_W     = 64;
   localparam int STATUS_W   = 3;
   localparam int SLOT_W     = 10;
   localparam int TOTAL_W    = 11;
   localparam int FOLD_SHIFT = 5;

   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_KEY  = 3'd4;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_FIND   = 1'b1;

   // closed form of h = (h + c) << 5 over the eleven characters
   function automatic logic [HASH_W-1:0] fold_hash(input logic [KEY_HEAD_W-1:0] head,
                                                   input logic [KEY_TAIL_W-1:0] tail);
      logic [HASH_W-1:0] h;
      logic [7:0]        c;
      h = '0;
      for (int i = 0; i < 8; i++) begin
         c = head[KEY_HEAD_W-1-8*i -: 8];
         h = h + ({56'd0, c} << (FOLD_SHIFT * (11 - i)));
      end
      for (int i = 0; i < 3; i++) begin
         c = tail[KEY_TAIL_W-1-8*i -: 8];
         h = h + ({56'd0, c} << (FOLD_SHIFT * (3 - i)));
      end
      return h;
   endfunction

endpackage

>>> sv/hash_set_linear_probe_unit.sv
// Hash set of 11-character keys, open addressing with linear probing in one
// synchronous slot memory of TABLE_DEPTH entries (88 bits: key head and tail).
// After reset the unit sweeps the memory to zero, one slot per cycle, and
// holds req_stall high meanwhile. One transaction is worked at a time: accept,
// hash, for a depth that is not a power of two a reduction of the hash by byte
// weights, a reciprocal multiply, a remainder and a final correction, a read
// issue, then the probe of successive slots, and the load of the result
// register. Keys with a zero first byte and inserts into a full table go from
// accept straight to the result register. The next transaction is accepted
// while the previous result still waits on rsp_stall.
`include "hash_set_linear_probe_unit_macros.svh"

module hash_set_linear_probe_unit #(
   parameter int TABLE_DEPTH = hslp_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_kind,
   input  logic [hslp_pkg::KEY_HEAD_W-1:0]   req_key_head,
   input  logic [hslp_pkg::KEY_TAIL_W-1:0]   req_key_tail,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [hslp_pkg::STATUS_W-1:0]     rsp_status,
   output logic [hslp_pkg::SLOT_W-1:0]       rsp_slot,
   output logic [hslp_pkg::TOTAL_W-1:0]      rsp_entry_total
);

   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
   localparam int SUM_W   = IDX_W + 11;

   function automatic logic [IDX_W-1:0] byte_weight(input int pos);
      return IDX_W'((64'd1 << (8 * pos)) % 64'(TABLE_DEPTH));
   endfunction

   localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [CNT_W-1:0] LAST_PROBE = CNT_W'(TABLE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(TABLE_DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_SUM  = SUM_W'(TABLE_DEPTH);
   localparam logic [SUM_W-1:0] RECIP      = SUM_W'((64'd1 << SUM_W) / 64'(TABLE_DEPTH));
   localparam logic [7:0][IDX_W-1:0] BYTE_WT = {byte_weight(7), byte_weight(6),
                                                byte_weight(5), byte_weight(4),
                                                byte_weight(3), byte_weight(2),
                                                byte_weight(1), byte_weight(0)};

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_HASH   = 7'b0000100,
      ST_MOD    = 7'b0001000,
      ST_ISSUE  = 7'b0010000,
      ST_CHECK  = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   state_type                           state_ff, state_in;
   logic                                kind_ff, kind_in;
   logic [hslp_pkg::KEY_HEAD_W-1:0]     head_ff, head_in;
   logic [hslp_pkg::KEY_TAIL_W-1:0]     tail_ff, tail_in;
   logic [hslp_pkg::HASH_W-1:0]         hash_ff, hash_in;
   logic [SUM_W-1:0]                    sum_ff, sum_in;
   logic [SUM_W-1:0]                    quot_ff, quot_in;
   logic [SUM_W-1:0]                    rem_ff, rem_in;
   logic [1:0]                          step_ff, step_in;
   logic [IDX_W-1:0]                    slot_ff, slot_in;
   logic [CNT_W-1:0]                    probe_ff, probe_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic [hslp_pkg::STATUS_W-1:0]       res_status_ff, res_status_in;
   logic [IDX_W-1:0]                    res_slot_ff, res_slot_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [hslp_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [hslp_pkg::SLOT_W-1:0]         rsp_slot_ff, rsp_slot_in;
   logic [hslp_pkg::TOTAL_W-1:0]        rsp_total_ff, rsp_total_in;

   logic [hslp_pkg::KEY_W-1:0]          slot_mem [TABLE_DEPTH];
   logic [hslp_pkg::KEY_W-1:0]          rd_data_ff;
   logic [IDX_W-1:0]                    rd_addr;
   logic                                wr_en;
   logic [hslp_pkg::KEY_W-1:0]          wr_data;

   logic [IDX_W-1:0]                    next_slot;
   logic [SUM_W-1:0]                    byte_sum;
   logic [2*SUM_W-1:0]                  quot_prod;
   logic [SUM_W-1:0]                    rem_raw;
   logic                                slot_empty;
   logic                                slot_match;
   logic                                req_accept;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[slot_ff] <= wr_data;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   always_comb begin
      byte_sum = '0;
      for (int i = 0; i < 8; i++) begin
         byte_sum = byte_sum + SUM_W'(hash_ff[8*i +: 8]) * SUM_W'(BYTE_WT[i]);
      end
   end

   assign quot_prod  = {{SUM_W{1'b0}}, sum_ff} * {{SUM_W{1'b0}}, RECIP};
   assign rem_raw    = sum_ff - quot_ff * DEPTH_SUM;
   assign next_slot  = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
   assign slot_empty = rd_data_ff[hslp_pkg::KEY_W-1 -: 8] == 8'd0;
   assign slot_match = rd_data_ff == {head_ff, tail_ff};
   assign req_stall  = state_ff != ST_IDLE;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      hash_in       = hash_ff;
      sum_in        = sum_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      slot_in       = slot_ff;
      probe_in      = probe_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_total_in  = rsp_total_ff;
      rd_addr       = slot_ff;
      wr_en         = 1'b0;
      wr_data       = {head_ff, tail_ff};

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
            slot_in = next_slot;
            if (slot_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               kind_in     = req_kind;
               head_in     = req_key_head;
               tail_in     = req_key_tail;
               res_slot_in = '0;
               if (req_key_head[hslp_pkg::KEY_HEAD_W-1 -: 8] == 8'd0) begin
                  res_status_in = hslp_pkg::STATUS_ZERO_KEY;
                  state_in      = ST_FINISH;
               end else if (req_kind == hslp_pkg::KIND_INSERT && count_ff >= DEPTH_CNT) begin
                  res_status_in = hslp_pkg::STATUS_FULL;
                  state_in      = ST_FINISH;
               end else begin
                  state_in = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            hash_in  = hslp_pkg::fold_hash(head_ff, tail_ff);
            step_in  = '0;
            state_in = IS_POW2 ? ST_ISSUE : ST_MOD;
            slot_in  = hash_in[IDX_W-1:0];
         end
         ST_MOD: begin
            step_in = step_ff + 1'b1;
            if (step_ff == 2'd0) begin
               sum_in = byte_sum;
            end else if (step_ff == 2'd1) begin
               quot_in = quot_prod[2*SUM_W-1:SUM_W];
            end else if (step_ff == 2'd2) begin
               rem_in = rem_raw;
            end else begin
               slot_in  = (rem_ff >= DEPTH_SUM) ? IDX_W'(rem_ff - DEPTH_SUM) : IDX_W'(rem_ff);
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            probe_in = '0;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            rd_addr = next_slot;
            if (slot_empty) begin
               if (kind_ff == hslp_pkg::KIND_INSERT) begin
                  wr_en         = 1'b1;
                  count_in      = count_ff + 1'b1;
                  res_status_in = hslp_pkg::STATUS_INSERTED;
                  res_slot_in   = slot_ff;
               end else begin
                  res_status_in = hslp_pkg::STATUS_NOT_FOUND;
               end
               state_in = ST_FINISH;
            end else if (kind_ff == hslp_pkg::KIND_FIND && slot_match) begin
               res_status_in = hslp_pkg::STATUS_FOUND;
               res_slot_in   = slot_ff;
               state_in      = ST_FINISH;
            end else if (probe_ff == LAST_PROBE) begin
               res_status_in = (kind_ff == hslp_pkg::KIND_INSERT) ? hslp_pkg::STATUS_FULL
                                                                  : hslp_pkg::STATUS_NOT_FOUND;
               state_in      = ST_FINISH;
            end else begin
               slot_in  = next_slot;
               probe_in = probe_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = hslp_pkg::SLOT_W'(res_slot_ff);
               rsp_total_in  = hslp_pkg::TOTAL_W'(count_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         slot_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      head_ff       <= head_in;
      tail_ff       <= tail_in;
      hash_ff       <= hash_in;
      sum_ff        <= sum_in;
      quot_ff       <= quot_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      probe_ff      <= probe_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_entry_total = rsp_total_ff;

   `HSLP_ASSERT(a_count_bound, clock, reset, count_ff <= DEPTH_CNT)
   `HSLP_ASSERT(a_write_source, clock, reset,
      wr_en |-> (state_ff == ST_CLEAR ||
                 (state_ff == ST_CHECK && kind_ff == hslp_pkg::KIND_INSERT)))
   `HSLP_ASSERT(a_probe_bound, clock, reset, (state_ff == ST_CHECK) |-> (probe_ff < DEPTH_CNT))
   `HSLP_ASSERT(a_count_on_insert, clock, reset,
      (!$past(reset) && count_ff != $past(count_ff)) |->
      (res_status_ff == hslp_pkg::STATUS_INSERTED && state_ff == ST_FINISH))
   `HSLP_ASSERT(a_rsp_from_finish, clock, reset,
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(state_ff == ST_FINISH))

endmodule
